@@ src/vsm_pkg.sv @@
// shared types, constants and helpers for the vector similarity metric block
`default_nettype none

package vsm_pkg;

   localparam int ELEMENT_BITS = 16;
   localparam int MAX_ELEMENTS = 4096;
   localparam int FRAC_BITS    = ELEMENT_BITS - 1;
   localparam int FIELD_W      = 16;
   localparam int ACC_W        = 48;
   localparam int ROOT_W       = ACC_W / 2;
   localparam int MUL_W        = ROOT_W + 1;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int SUM_W        = ACC_W + 2;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 2);
   localparam int STEP_W       = $clog2(ROOT_W + 1);
   localparam int MODE_W       = 2;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_ADDR_W-3:0] CSR_METRIC_MODE = '0;

   localparam logic signed [SUM_W-1:0] SUM_SMAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SUM_SMIN = -SUM_SMAX - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SUM_UMAX = SUM_W'((64'sd1 <<< ACC_W) - 64'sd1);

   localparam logic signed [ACC_W-1:0] COS_MAX = ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
   localparam logic signed [ACC_W-1:0] COS_MIN = ~COS_MAX;

   localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ROOT_W);
   localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(FRAC_BITS);

   typedef enum logic [MODE_W-1:0] {
      MODE_DOT    = 2'd0,
      MODE_NORM   = 2'd1,
      MODE_DIST   = 2'd2,
      MODE_COSINE = 2'd3
   } metric_mode_type;

   typedef enum logic [2:0] {
      MAC_DOT  = 3'd0,
      MAC_SQA  = 3'd1,
      MAC_SQB  = 3'd2,
      MAC_DIFF = 3'd3,
      MAC_NORM = 3'd4
   } mac_op_type;

   typedef struct packed {
      logic       issue;
      mac_op_type op;
      logic       clear;
   } mac_cmd_type;

   typedef enum logic {
      IT_SQRT = 1'b0,
      IT_DIV  = 1'b1
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_stat_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] elem_a;
      logic signed [FIELD_W-1:0] elem_b;
      logic                      last_element;
   } req_word_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] metric_value;
      logic                    zero_norm;
      logic                    too_long;
   } rsp_word_type;

   function automatic logic signed [MUL_W-1:0] sext_elem(input logic [FIELD_W-1:0] raw);
      return {{(MUL_W-ELEMENT_BITS){raw[ELEMENT_BITS-1]}}, raw[ELEMENT_BITS-1:0]};
   endfunction

endpackage

`default_nettype wire

@@ src/vsm_mac.sv @@
// shared multiplier with the four saturating accumulators
`default_nettype none

module vsm_mac import vsm_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mac_cmd_type              mac_cmd,
   input  wire logic signed [MUL_W-1:0]  opnd_a,
   input  wire logic signed [MUL_W-1:0]  opnd_b,
   output logic signed [ACC_W-1:0]       dot_sum,
   output logic [ACC_W-1:0]              square_sum_a,
   output logic [ACC_W-1:0]              square_sum_b,
   output logic [ACC_W-1:0]              diff_square_sum,
   output logic [ACC_W-1:0]              norm_product
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pvalid_ff, pvalid_in;
   mac_op_type               ptag_ff, ptag_in;
   logic signed [ACC_W-1:0]  dot_ff, dot_in;
   logic [ACC_W-1:0]         sqa_ff, sqa_in;
   logic [ACC_W-1:0]         sqb_ff, sqb_in;
   logic [ACC_W-1:0]         dsq_ff, dsq_in;

   logic signed [SUM_W-1:0]  acc_ext;
   logic signed [SUM_W-1:0]  sum;
   logic [ACC_W-1:0]         sat_val;

   always_comb begin
      prod_in   = opnd_a * opnd_b;
      pvalid_in = mac_cmd.issue;
      ptag_in   = mac_cmd.op;

      case (ptag_ff)
         MAC_DOT:  acc_ext = SUM_W'(dot_ff);
         MAC_SQA:  acc_ext = $signed(SUM_W'(sqa_ff));
         MAC_SQB:  acc_ext = $signed(SUM_W'(sqb_ff));
         MAC_DIFF: acc_ext = $signed(SUM_W'(dsq_ff));
         default:  acc_ext = '0;
      endcase
      sum = acc_ext + SUM_W'(prod_ff);

      // signed clamp for the dot sum, upper clamp for the square sums
      if (ptag_ff == MAC_DOT) begin
         if (sum > SUM_SMAX) begin
            sat_val = SUM_SMAX[ACC_W-1:0];
         end else if (sum < SUM_SMIN) begin
            sat_val = SUM_SMIN[ACC_W-1:0];
         end else begin
            sat_val = sum[ACC_W-1:0];
         end
      end else if (sum > SUM_UMAX) begin
         sat_val = SUM_UMAX[ACC_W-1:0];
      end else begin
         sat_val = sum[ACC_W-1:0];
      end

      dot_in = dot_ff;
      sqa_in = sqa_ff;
      sqb_in = sqb_ff;
      dsq_in = dsq_ff;
      if (mac_cmd.clear) begin
         dot_in = '0;
         sqa_in = '0;
         sqb_in = '0;
         dsq_in = '0;
      end else if (pvalid_ff) begin
         case (ptag_ff)
            MAC_DOT:  dot_in = $signed(sat_val);
            MAC_SQA:  sqa_in = sat_val;
            MAC_SQB:  sqb_in = sat_val;
            MAC_DIFF: dsq_in = sat_val;
            default:  dot_in = dot_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ptag_ff <= ptag_in;
      if (reset) begin
         pvalid_ff <= 1'b0;
         dot_ff    <= '0;
         sqa_ff    <= '0;
         sqb_ff    <= '0;
         dsq_ff    <= '0;
      end else begin
         pvalid_ff <= pvalid_in;
         dot_ff    <= dot_in;
         sqa_ff    <= sqa_in;
         sqb_ff    <= sqb_in;
         dsq_ff    <= dsq_in;
      end
   end

   assign dot_sum         = dot_ff;
   assign square_sum_a    = sqa_ff;
   assign square_sum_b    = sqb_ff;
   assign diff_square_sum = dsq_ff;
   assign norm_product    = prod_ff[ACC_W-1:0];

endmodule

`default_nettype wire

@@ src/vsm_iter.sv @@
// shift-subtract unit shared by the square roots and the cosine division
`default_nettype none

module vsm_iter import vsm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire iter_cmd_type       iter_cmd,
   input  wire logic [ACC_W-1:0]   operand,
   input  wire logic [ACC_W-1:0]   divisor,
   output iter_stat_type           iter_stat,
   output logic [ROOT_W-1:0]       iter_result
);

   iter_op_type         op_ff, op_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [ACC_W:0]      rem_ff, rem_in;
   logic [ACC_W-1:0]    root_ff, root_in;
   logic [ACC_W-1:0]    bit_ff, bit_in;
   logic [ACC_W-1:0]    den_ff, den_in;

   logic [ACC_W:0]      sub_x;
   logic [ACC_W:0]      sub_y;
   logic [ACC_W+1:0]    diff;
   logic                ge;

   always_comb begin
      if (op_ff == IT_SQRT) begin
         sub_x = rem_ff;
         sub_y = {1'b0, root_ff} + {1'b0, bit_ff};
      end else begin
         sub_x = {rem_ff[ACC_W-1:0], 1'b0};
         sub_y = {1'b0, den_ff};
      end
      diff = {1'b0, sub_x} - {1'b0, sub_y};
      ge   = ~diff[ACC_W+1];

      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      den_in  = den_ff;

      if (iter_cmd.start) begin
         op_in   = iter_cmd.op;
         busy_in = 1'b1;
         rem_in  = {1'b0, operand};
         root_in = '0;
         bit_in  = {2'b01, {(ACC_W-2){1'b0}}};
         den_in  = divisor;
         cnt_in  = (iter_cmd.op == IT_SQRT) ? SQRT_STEPS : DIV_STEPS;
      end else if (busy_ff) begin
         if (op_ff == IT_SQRT) begin
            if (ge) begin
               rem_in  = diff[ACC_W:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end else begin
            rem_in  = ge ? diff[ACC_W:0] : sub_x;
            root_in = {root_ff[ACC_W-2:0], ge};
         end
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      den_ff  <= den_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign iter_stat.busy = busy_ff;
   assign iter_stat.done = done_ff;
   assign iter_result    = root_ff[ROOT_W-1:0];

endmodule

`default_nettype wire

@@ src/vector_similarity_metric.sv @@
// top level: element sequencer, result register and configuration port
`default_nettype none

// Takes one pair of Q1.15 elements per word and returns one result word per vector, on
// the word marked last. One 25x25 multiplier is reused four times per element (a*b, a*a,
// b*b, (a-b)^2), so a new word is taken only after all four products of the element are
// issued. On the last element the result is then formed: from the dot sum for mode 0; by
// one 24-step square root for modes 1 and 2; by two square roots, the norm product and a
// 15-step division for mode 3, ending early when a norm is zero or the cosine saturates.
// The square roots and the division share one shift-subtract unit doing one step per cycle.
// A finished result waits in its output register while the next vector is streamed in.

module vector_similarity_metric import vsm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_word_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_word_type                rsp_data,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]       prdata,
   output logic                        pready
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_DRAIN,
      S_EVAL,
      S_ROOT_A,
      S_ROOT_B,
      S_CHECK,
      S_DIV,
      S_OUT
   } state_type;

   state_type                 state_ff, state_in;
   metric_mode_type           mode_ff, mode_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [1:0]                mul_cnt_ff, mul_cnt_in;
   logic signed [MUL_W-1:0]   a_ff, a_in;
   logic signed [MUL_W-1:0]   b_ff, b_in;
   logic signed [MUL_W-1:0]   d_ff, d_in;
   logic                      last_ff, last_in;
   logic [ROOT_W-1:0]         na_ff, na_in;
   logic signed [ACC_W-1:0]   value_ff, value_in;
   logic                      zn_ff, zn_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_ff, rsp_in;

   mac_cmd_type               mac_cmd;
   mac_op_type                mul_op;
   logic signed [MUL_W-1:0]   opnd_a;
   logic signed [MUL_W-1:0]   opnd_b;
   logic signed [ACC_W-1:0]   dot_sum;
   logic [ACC_W-1:0]          square_sum_a;
   logic [ACC_W-1:0]          square_sum_b;
   logic [ACC_W-1:0]          diff_square_sum;
   logic [ACC_W-1:0]          norm_product;

   iter_cmd_type              iter_cmd;
   iter_stat_type             iter_stat;
   logic [ACC_W-1:0]          iter_operand;
   logic [ROOT_W-1:0]         iter_result;

   logic                      dot_neg;
   logic [ACC_W-1:0]          dot_mag;
   logic signed [ACC_W-1:0]   q_val;
   logic                      csr_write;

   vsm_mac u_mac (
      .clock           (clock),
      .reset           (reset),
      .mac_cmd         (mac_cmd),
      .opnd_a          (opnd_a),
      .opnd_b          (opnd_b),
      .dot_sum         (dot_sum),
      .square_sum_a    (square_sum_a),
      .square_sum_b    (square_sum_b),
      .diff_square_sum (diff_square_sum),
      .norm_product    (norm_product)
   );

   vsm_iter u_iter (
      .clock       (clock),
      .reset       (reset),
      .iter_cmd    (iter_cmd),
      .operand     (iter_operand),
      .divisor     (norm_product),
      .iter_stat   (iter_stat),
      .iter_result (iter_result)
   );

   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == CSR_METRIC_MODE) begin
         prdata[MODE_W-1:0] = mode_ff;
      end
   end

   assign dot_neg = dot_sum[ACC_W-1];
   assign dot_mag = dot_neg ? (-dot_sum) : dot_sum;
   assign q_val   = $signed({{(ACC_W-ROOT_W){1'b0}}, iter_result});
   assign mul_op  = mac_op_type'({1'b0, mul_cnt_ff});

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      mul_cnt_in   = mul_cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      last_in      = last_ff;
      na_in        = na_ff;
      value_in     = value_ff;
      zn_in        = zn_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      mac_cmd.issue = 1'b0;
      mac_cmd.op    = MAC_DOT;
      mac_cmd.clear = 1'b0;
      opnd_a        = a_ff;
      opnd_b        = b_ff;
      iter_cmd.start = 1'b0;
      iter_cmd.op    = IT_SQRT;
      iter_operand   = square_sum_a;

      if (csr_write && paddr[CSR_ADDR_W-1:2] == CSR_METRIC_MODE) begin
         mode_in = metric_mode_type'(pwdata[MODE_W-1:0]);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a_in       = sext_elem(req_data.elem_a);
               b_in       = sext_elem(req_data.elem_b);
               d_in       = sext_elem(req_data.elem_a) - sext_elem(req_data.elem_b);
               last_in    = req_data.last_element;
               mul_cnt_in = '0;
               if (count_ff <= CNT_W'(MAX_ELEMENTS)) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            mac_cmd.issue = 1'b1;
            mac_cmd.op    = mul_op;
            case (mul_op)
               MAC_DOT: begin
                  opnd_a = a_ff;
                  opnd_b = b_ff;
               end
               MAC_SQA: begin
                  opnd_a = a_ff;
                  opnd_b = a_ff;
               end
               MAC_SQB: begin
                  opnd_a = b_ff;
                  opnd_b = b_ff;
               end
               default: begin
                  opnd_a = d_ff;
                  opnd_b = d_ff;
               end
            endcase
            mul_cnt_in = mul_cnt_ff + 2'd1;
            if (mul_op == MAC_DIFF) begin
               state_in = last_ff ? S_DRAIN : S_IDLE;
            end
         end
         S_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            zn_in = 1'b0;
            case (mode_ff)
               MODE_DOT: begin
                  value_in = dot_sum;
                  state_in = S_OUT;
               end
               default: begin
                  iter_cmd.start = 1'b1;
                  iter_cmd.op    = IT_SQRT;
                  iter_operand   = (mode_ff == MODE_DIST) ? diff_square_sum : square_sum_a;
                  state_in       = S_ROOT_A;
               end
            endcase
         end
         S_ROOT_A: begin
            iter_operand = square_sum_b;
            if (iter_stat.done) begin
               na_in = iter_result;
               if (mode_ff == MODE_COSINE) begin
                  iter_cmd.start = 1'b1;
                  iter_cmd.op    = IT_SQRT;
                  state_in       = S_ROOT_B;
               end else begin
                  value_in = q_val;
                  state_in = S_OUT;
               end
            end
         end
         S_ROOT_B: begin
            opnd_a = $signed({1'b0, na_ff});
            opnd_b = $signed({1'b0, iter_result});
            if (iter_stat.done) begin
               if (na_ff == '0 || iter_result == '0) begin
                  value_in = '0;
                  zn_in    = 1'b1;
                  state_in = S_OUT;
               end else begin
                  mac_cmd.issue = 1'b1;
                  mac_cmd.op    = MAC_NORM;
                  state_in      = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            iter_operand = dot_mag;
            if (dot_mag >= norm_product) begin
               value_in = dot_neg ? COS_MIN : COS_MAX;
               state_in = S_OUT;
            end else begin
               iter_cmd.start = 1'b1;
               iter_cmd.op    = IT_DIV;
               state_in       = S_DIV;
            end
         end
         S_DIV: begin
            if (iter_stat.done) begin
               value_in = dot_neg ? -q_val : q_val;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.metric_value = value_ff;
               rsp_in.zero_norm    = zn_ff;
               rsp_in.too_long     = (count_ff > CNT_W'(MAX_ELEMENTS));
               rsp_valid_in        = 1'b1;
               mac_cmd.clear       = 1'b1;
               count_in            = '0;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      d_ff     <= d_in;
      last_ff  <= last_in;
      na_ff    <= na_in;
      value_ff <= value_in;
      zn_ff    <= zn_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_DOT;
         count_ff     <= '0;
         mul_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         mul_cnt_ff   <= mul_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_zero_norm_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_norm |-> rsp_data.metric_value == '0)
      else $error("zero_norm word carries a nonzero value");

   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !iter_stat.busy)
      else $error("shift-subtract unit busy while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS + 1))
      else $error("element count past its hold value");

   a_word_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result word raised outside the output state");

endmodule

`default_nettype wire
